/* design/pipe_field_splitter_percent_decoder_core_defines.svh */
// Assertion macros for the field splitter core.
// Each expects clk and rst_n in scope.
`ifndef PIPE_FIELD_SPLITTER_PERCENT_DECODER_CORE_DEFINES_SVH
`define PIPE_FIELD_SPLITTER_PERCENT_DECODER_CORE_DEFINES_SVH

`ifndef ASSERT_OFF
`define PFS_ASSERT_ALWAYS(label, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);
`define PFS_ASSERT_IMPLY(label, cond, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (prop)) \
        else $error(msg);
`else
`define PFS_ASSERT_ALWAYS(label, prop, msg)
`define PFS_ASSERT_IMPLY(label, cond, prop, msg)
`endif

`endif

/* design/pfs_pkg.sv */
package pfs_pkg;

    localparam logic [7:0] CH_PERCENT = 8'h25;
    localparam logic [7:0] CH_PIPE    = 8'h7C;
    localparam logic [7:0] CH_NEWLINE = 8'h0A;

    localparam int TOKEN_INDEX_MAX = 15;
    localparam int TOKEN_W         = 4;
    localparam logic [TOKEN_W-1:0] TOKEN_LIMIT =
        TOKEN_W'((TOKEN_INDEX_MAX > 15) ? 15 : TOKEN_INDEX_MAX);

    localparam int MAX_RES = 4;
    localparam int NRES_W  = $clog2(MAX_RES + 1);
    localparam int RIDX_W  = $clog2(MAX_RES);

    localparam int QDEPTH = 8;
    localparam int QPTR_W = $clog2(QDEPTH);
    localparam int QCNT_W = $clog2(QDEPTH + 1);

    typedef enum logic [1:0] {
        KIND_DATA      = 2'd0,
        KIND_TOKEN_END = 2'd1,
        KIND_LINE_END  = 2'd2
    } kind_t;

    typedef enum logic [1:0] {
        ESC_NONE    = 2'd0,
        ESC_PERCENT = 2'd1,
        ESC_DIGIT   = 2'd2
    } esc_t;

    typedef struct packed {
        kind_t              kind;
        logic [7:0]         data_byte;
        logic [TOKEN_W-1:0] token_number;
        logic               run_last;
    } result_t;

    typedef struct packed {
        logic [NRES_W-1:0]         n;
        result_t [MAX_RES-1:0]     res;
    } push_t;

    typedef struct packed {
        logic              space_ok;
        logic [QCNT_W-1:0] count;
    } qstat_t;

    function automatic logic hex_ok(input logic [7:0] c);
        return (c >= 8'h30 && c <= 8'h39) || (c >= 8'h41 && c <= 8'h46) ||
               (c >= 8'h61 && c <= 8'h66);
    endfunction

    function automatic logic [3:0] hex_val(input logic [7:0] c);
        logic [7:0] v;
        v = 8'h00;
        if (c >= 8'h30 && c <= 8'h39)
        begin
            v = c - 8'h30;
        end
        else if (c >= 8'h41 && c <= 8'h46)
        begin
            v = c - 8'h37;
        end
        else if (c >= 8'h61 && c <= 8'h66)
        begin
            v = c - 8'h57;
        end
        return v[3:0];
    endfunction

endpackage

/* design/pfs_raw_if.sv */
interface pfs_raw_if;
    logic       valid;
    logic       ready;
    logic [7:0] raw_byte;
    logic       line_last;

    modport source (output valid, output raw_byte, output line_last, input ready);
    modport sink (input valid, input raw_byte, input line_last, output ready);
endinterface

/* design/pfs_field_if.sv */
interface pfs_field_if;
    logic       valid;
    logic       ready;
    logic [1:0] kind;
    logic [7:0] data_byte;
    logic [3:0] token_number;
    logic       run_last;

    modport source (output valid, output kind, output data_byte, output token_number,
                    output run_last, input ready);
    modport sink (input valid, input kind, input data_byte, input token_number,
                  input run_last, output ready);
endinterface

/* design/pfs_decode.sv */
module pfs_decode
    import pfs_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    pfs_raw_if.sink   raw,
    input  qstat_t    qstat,
    output push_t     push
);

    logic               in_valid_reg;
    logic [7:0]         byte_reg;
    logic               last_reg;
    esc_t               esc_reg;
    esc_t               esc_next;
    logic [7:0]         digit_reg;
    logic [7:0]         digit_next;
    logic [TOKEN_W-1:0] token_reg;
    logic [TOKEN_W-1:0] token_next;
    logic               consume;
    logic [NRES_W-1:0]  n;
    result_t [MAX_RES-1:0] res;

    assign consume   = in_valid_reg && qstat.space_ok;
    assign raw.ready = !in_valid_reg || consume;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
            esc_reg      <= ESC_NONE;
            token_reg    <= '0;
        end
        else
        begin
            if (raw.ready)
            begin
                in_valid_reg <= raw.valid;
            end
            if (consume)
            begin
                esc_reg   <= esc_next;
                token_reg <= token_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (raw.valid && raw.ready)
        begin
            byte_reg <= raw.raw_byte;
            last_reg <= raw.line_last;
        end
        if (consume)
        begin
            digit_reg <= digit_next;
        end
    end

    function automatic result_t mk(input kind_t k, input logic [7:0] d,
                                   input logic [TOKEN_W-1:0] t);
        result_t r;
        r.kind         = k;
        r.data_byte    = (k == KIND_DATA) ? d : 8'h00;
        r.token_number = t;
        r.run_last     = 1'b0;
        return r;
    endfunction

    // Build every result of the held byte; at most four come out.
    always_comb
    begin
        logic idle;
        logic do_feed;
        esc_next   = esc_reg;
        digit_next = digit_reg;
        token_next = token_reg;
        n          = '0;
        res        = '0;
        idle       = 1'b0;
        do_feed    = (byte_reg != CH_PIPE) && !(last_reg && byte_reg == CH_NEWLINE);

        if (do_feed)
        begin
            unique case (esc_reg)
                ESC_PERCENT:
                begin
                    if (hex_ok(byte_reg))
                    begin
                        digit_next = byte_reg;
                        esc_next   = ESC_DIGIT;
                    end
                    else
                    begin
                        res[n[RIDX_W-1:0]] = mk(KIND_DATA, CH_PERCENT, token_reg);
                        n = n + 1'b1;
                        esc_next = ESC_NONE;
                        idle     = 1'b1;
                    end
                end
                ESC_DIGIT:
                begin
                    if (hex_ok(byte_reg))
                    begin
                        res[n[RIDX_W-1:0]] = mk(KIND_DATA,
                                                {hex_val(digit_reg), hex_val(byte_reg)},
                                                token_reg);
                        n = n + 1'b1;
                    end
                    else
                    begin
                        res[n[RIDX_W-1:0]] = mk(KIND_DATA, CH_PERCENT, token_reg);
                        n = n + 1'b1;
                        res[n[RIDX_W-1:0]] = mk(KIND_DATA, digit_reg, token_reg);
                        n = n + 1'b1;
                        idle = 1'b1;
                    end
                    esc_next = ESC_NONE;
                end
                default:
                begin
                    esc_next = ESC_NONE;
                    idle     = 1'b1;
                end
            endcase

            if (idle)
            begin
                if (byte_reg == CH_PERCENT)
                begin
                    esc_next = ESC_PERCENT;
                end
                else
                begin
                    res[n[RIDX_W-1:0]] = mk(KIND_DATA, byte_reg, token_reg);
                    n = n + 1'b1;
                end
            end
        end

        // Token or line end: release any open escape as literal data first.
        if (byte_reg == CH_PIPE || last_reg)
        begin
            if (esc_next == ESC_PERCENT || esc_next == ESC_DIGIT)
            begin
                res[n[RIDX_W-1:0]] = mk(KIND_DATA, CH_PERCENT, token_reg);
                n = n + 1'b1;
            end
            if (esc_next == ESC_DIGIT)
            begin
                res[n[RIDX_W-1:0]] = mk(KIND_DATA, digit_next, token_reg);
                n = n + 1'b1;
            end
            esc_next = ESC_NONE;
            if (last_reg)
            begin
                res[n[RIDX_W-1:0]] = mk(KIND_LINE_END, 8'h00, token_reg);
                n = n + 1'b1;
                token_next = '0;
            end
            else
            begin
                res[n[RIDX_W-1:0]] = mk(KIND_TOKEN_END, 8'h00, token_reg);
                n = n + 1'b1;
                if (token_reg < TOKEN_LIMIT)
                begin
                    token_next = token_reg + 1'b1;
                end
            end
        end

        for (int i = 0; i < MAX_RES; i++)
        begin
            res[i].run_last = (NRES_W'(i + 1) == n);
        end
    end

    assign push.n   = consume ? n : '0;
    assign push.res = res;

endmodule

/* design/pfs_queue.sv */
module pfs_queue
    import pfs_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  push_t      push,
    output qstat_t     qstat,
    pfs_field_if.source field
);

    result_t           mem_reg [QDEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg;
    logic [QPTR_W-1:0] rd_ptr_reg;
    logic [QCNT_W-1:0] count_reg;
    logic [QCNT_W-1:0] count_next;
    logic              pop;
    result_t           head;

    assign pop        = field.valid && field.ready;
    assign count_next = count_reg + QCNT_W'(push.n) - QCNT_W'(pop);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_reg + QPTR_W'(push.n);
            if (pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        for (int i = 0; i < MAX_RES; i++)
        begin
            if (NRES_W'(i) < push.n)
            begin
                mem_reg[wr_ptr_reg + QPTR_W'(i)] <= push.res[i];
            end
        end
    end

    // Room for a whole burst is needed before the decoder may advance.
    assign qstat.space_ok = (count_reg <= QCNT_W'(QDEPTH - MAX_RES));
    assign qstat.count    = count_reg;

    assign head               = mem_reg[rd_ptr_reg];
    assign field.valid        = (count_reg != '0);
    assign field.kind         = head.kind;
    assign field.data_byte    = head.data_byte;
    assign field.token_number = head.token_number;
    assign field.run_last     = head.run_last;

endmodule

/* design/pipe_field_splitter_percent_decoder_core.sv */
// Splits a text line, one raw byte per transfer, into pipe-delimited tokens and
// percent-decodes each token. Each result is a decoded data byte, a token end or
// a line end, tagged with its token index (saturating) and with run_last on the
// final result of its input byte. A byte is taken into an input register, decoded
// from it into up to four results once the queue has room, and these are written
// at once into an eight-entry result queue that drains one transfer per cycle
// while the sink is ready. An input byte is accepted every cycle while the queue
// has room for four more results; the sustained rate is therefore at most one
// input byte per cycle, bounded by the single result transfer per cycle of the
// queue's read side. Each byte passes through the input register and the queue.
`include "pipe_field_splitter_percent_decoder_core_defines.svh"

module pipe_field_splitter_percent_decoder_core
    import pfs_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    pfs_raw_if.sink     raw,
    pfs_field_if.source field
);

    push_t  push;
    qstat_t qstat;
    logic   line_end_out;
    logic   marker_out;

    pfs_decode u_decode (
        .clk   (clk),
        .rst_n (rst_n),
        .raw   (raw),
        .qstat (qstat),
        .push  (push)
    );

    pfs_queue u_queue (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (push),
        .qstat (qstat),
        .field (field)
    );

    assign line_end_out = field.valid && field.kind == KIND_LINE_END;
    assign marker_out   = field.valid && field.kind != KIND_DATA;

    `PFS_ASSERT_ALWAYS(a_queue_bound, qstat.count <= QCNT_W'(QDEPTH), "result queue overrun")
    `PFS_ASSERT_IMPLY(a_line_end_last, line_end_out, field.run_last, "line end not last")
    `PFS_ASSERT_IMPLY(a_marker_data_zero, marker_out, field.data_byte == 8'h00, "marker has data")

endmodule
